/* src/ctmt_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package ctmt_pkg;

   localparam int COUNT_W    = 32;
   localparam int TOTAL_W    = 32;
   localparam int CPU_W      = 10;
   localparam int INTERVAL_W = 16;
   localparam int OP_W       = 2;
   localparam int DIVIDEND_W = COUNT_W + 1;
   localparam int CSR_DATA_W = 16;
   localparam int CSR_INDEX_W = 1;

   localparam logic [CPU_W-1:0]      CPU_RESET      = 10'd168;
   localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 16'd100;

   typedef enum logic [OP_W-1:0] {
      OP_SAMPLE = 2'd0,
      OP_FIXED  = 2'd1,
      OP_RESET  = 2'd2
   } op_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_TICK_RATE         = 1'd0,
      CSR_FIXED_INTERVAL_US = 1'd1
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SUM,
      ST_DIVIDE,
      ST_RESPOND
   } state_type;

endpackage

`default_nettype wire

/* src/ctmt_div.sv */
`timescale 1ns / 1ps
`default_nettype none

module ctmt_div #(
   parameter int DIVIDEND_WIDTH = ctmt_pkg::DIVIDEND_W,
   parameter int DIVISOR_WIDTH  = ctmt_pkg::CPU_W
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   input  wire logic [DIVIDEND_WIDTH-1:0] dividend,
   input  wire logic [DIVISOR_WIDTH-1:0]  divisor,
   output logic                           done,
   output logic [DIVIDEND_WIDTH-1:0]      quotient,
   output logic [DIVISOR_WIDTH-1:0]       remainder
);
   import ctmt_pkg::*;

   localparam int STEP_W = $clog2(DIVIDEND_WIDTH + 1);

   logic                      busy_ff, busy_in;
   logic                      done_ff, done_in;
   logic [STEP_W-1:0]         step_ff, step_in;
   logic [DIVIDEND_WIDTH-1:0] quo_ff, quo_in;
   logic [DIVISOR_WIDTH-1:0]  rem_ff, rem_in;
   logic [DIVISOR_WIDTH-1:0]  dsr_ff, dsr_in;
   logic [DIVISOR_WIDTH:0]    trial;
   logic [DIVISOR_WIDTH:0]    diff;
   logic                      fits;

   assign trial = {rem_ff, quo_ff[DIVIDEND_WIDTH-1]};
   assign diff  = trial - {1'b0, dsr_ff};
   assign fits  = trial >= {1'b0, dsr_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = STEP_W'(DIVIDEND_WIDTH);
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         quo_in  = {quo_ff[DIVIDEND_WIDTH-2:0], fits};
         rem_in  = fits ? diff[DIVISOR_WIDTH-1:0] : trial[DIVISOR_WIDTH-1:0];
         step_in = step_ff - STEP_W'(1);
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire

/* src/cycles_to_microsecond_timestamp.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel | Direction | Ports  | Contents
// req     | in        | req_*  | tuser[1:0] op, tdata[31:0] cycle_count
// rsp     | out       | rsp_*  | tdata[31:0] timestamp_us
// csr     | in        | csr_*  | write enable, register index, write data
//
// A sample request forms the count difference, adds the carried remainder and loads the
// divider, runs 33 divider steps, updates the total and then loads the output register.
// Other requests, and samples at a zero rate, go straight to the response state,
// which loads the output register.
// The synchronous reset restores the register defaults and clears all totals.
// A stalled response holds the block after its current request until the transfer.
module cycles_to_microsecond_timestamp (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   input  wire logic [ctmt_pkg::COUNT_W-1:0]         req_tdata,  // [31:0] cycle_count
   input  wire logic [ctmt_pkg::OP_W-1:0]            req_tuser,  // [1:0] op
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   output logic [ctmt_pkg::TOTAL_W-1:0]              rsp_tdata,  // [31:0] timestamp_us
   input  wire logic                                 csr_we,
   input  wire logic [ctmt_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [ctmt_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import ctmt_pkg::*;

   state_type             state_ff, state_in;
   logic [CPU_W-1:0]      cpu_ff, cpu_in;
   logic [INTERVAL_W-1:0] interval_ff, interval_in;
   logic [COUNT_W-1:0]    last_ff, last_in;
   logic [TOTAL_W-1:0]    total_ff, total_in;
   logic [CPU_W-1:0]      rem_ff, rem_in;
   logic [TOTAL_W-1:0]    stamp_ff, stamp_in;
   logic [COUNT_W-1:0]    delta_ff, delta_in;
   logic [TOTAL_W-1:0]    result_ff, result_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [TOTAL_W-1:0]    rsp_data_ff, rsp_data_in;

   logic                  accept;
   logic                  div_start;
   logic [DIVIDEND_W-1:0] div_dividend;
   logic                  div_done;
   logic [DIVIDEND_W-1:0] div_quotient;
   logic [CPU_W-1:0]      div_remainder;

   assign accept       = req_tvalid && req_tready;
   assign div_start    = state_ff == ST_SUM;
   assign div_dividend = {1'b0, delta_ff} + {{(DIVIDEND_W-CPU_W){1'b0}}, rem_ff};

   ctmt_div #(
      .DIVIDEND_WIDTH (DIVIDEND_W),
      .DIVISOR_WIDTH  (CPU_W)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (cpu_ff),
      .done      (div_done),
      .quotient  (div_quotient),
      .remainder (div_remainder)
   );

   always_comb begin
      state_in     = state_ff;
      cpu_in       = cpu_ff;
      interval_in  = interval_ff;
      last_in      = last_ff;
      total_in     = total_ff;
      rem_in       = rem_ff;
      stamp_in     = stamp_ff;
      delta_in     = delta_ff;
      result_in    = result_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      req_tready   = state_ff == ST_IDLE;

      if (csr_we) begin
         case (csr_index)
            CSR_TICK_RATE:         cpu_in      = csr_wdata[CPU_W-1:0];
            CSR_FIXED_INTERVAL_US: interval_in = csr_wdata[INTERVAL_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_tuser)
                  OP_FIXED: begin
                     stamp_in  = stamp_ff + {{(TOTAL_W-INTERVAL_W){1'b0}}, interval_ff};
                     result_in = stamp_in;
                     state_in  = ST_RESPOND;
                  end
                  OP_RESET: begin
                     total_in  = '0;
                     rem_in    = '0;
                     stamp_in  = '0;
                     last_in   = req_tdata;
                     result_in = '0;
                     state_in  = ST_RESPOND;
                  end
                  default: begin
                     last_in  = req_tdata;
                     delta_in = req_tdata - last_ff;
                     if (cpu_ff == '0) begin
                        rem_in    = '0;
                        result_in = total_ff;
                        state_in  = ST_RESPOND;
                     end else begin
                        state_in = ST_SUM;
                     end
                  end
               endcase
            end
         end
         ST_SUM: begin
            state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (div_done) begin
               total_in  = total_ff + div_quotient[TOTAL_W-1:0];
               rem_in    = div_remainder;
               result_in = total_in;
               state_in  = ST_RESPOND;
            end
         end
         ST_RESPOND: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = result_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cpu_ff       <= CPU_RESET;
         interval_ff  <= INTERVAL_RESET;
         last_ff      <= '0;
         total_ff     <= '0;
         rem_ff       <= '0;
         stamp_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cpu_ff       <= cpu_in;
         interval_ff  <= interval_in;
         last_ff      <= last_in;
         total_ff     <= total_in;
         rem_ff       <= rem_in;
         stamp_ff     <= stamp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      delta_ff    <= delta_in;
      result_ff   <= result_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

/* src/ctmt_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module ctmt_checker (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              req_tvalid,
   input wire logic                              req_tready,
   input wire logic [ctmt_pkg::OP_W-1:0]         req_tuser,
   input wire logic                              rsp_tvalid,
   input wire logic                              rsp_tready,
   input wire logic [ctmt_pkg::TOTAL_W-1:0]      rsp_tdata
);
   import ctmt_pkg::*;

   logic req_xfer;

   assign req_xfer = req_tvalid && req_tready;

   // No response is offered right after a reset.
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response offered after reset");

   // The block works on one request at a time.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> !req_tready)
      else $error("request accepted while busy");

   // A reset request taken while the output is free returns zero via the response state.
   a_reset_zero: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && req_tuser == OP_RESET && !rsp_tvalid)
         |-> ##2 (rsp_tvalid && rsp_tdata == '0))
      else $error("reset request did not return zero");

   // A stalled response keeps its data.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled response changed");

endmodule

bind cycles_to_microsecond_timestamp ctmt_checker u_ctmt_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

/* tb/ctmt_timestamp_checker.sv */
`timescale 1ns / 1ps

module ctmt_timestamp_checker (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tvalid,
   input  wire logic                             req_tready,
   input  wire logic [ctmt_pkg::COUNT_W-1:0]     req_tdata,
   input  wire logic [ctmt_pkg::OP_W-1:0]        req_tuser,
   input  wire logic                             rsp_tvalid,
   input  wire logic                             rsp_tready,
   input  wire logic [ctmt_pkg::TOTAL_W-1:0]     rsp_tdata,
   input  wire logic                             csr_we,
   input  wire logic [ctmt_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [ctmt_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output int                                    mismatches,
   output int                                    pending,
   output int                                    checked
);
   import ctmt_pkg::*;

   logic [CPU_W-1:0]      tick_rate;
   logic [INTERVAL_W-1:0] fixed_interval_us;
   logic [COUNT_W-1:0]    last_count;
   logic [TOTAL_W-1:0]    micro_total;
   logic [CPU_W-1:0]      carry_cycles;
   logic [TOTAL_W-1:0]    fixed_stamp;
   logic [TOTAL_W-1:0]    expected_stamps[$];

   task automatic predict_timestamp(input logic [OP_W-1:0] op,
                                    input logic [COUNT_W-1:0] count);
      logic [COUNT_W-1:0]    delta;
      logic [DIVIDEND_W-1:0] dividend;
      logic [DIVIDEND_W-1:0] divisor;
      logic [DIVIDEND_W-1:0] quotient;
      logic [TOTAL_W-1:0]    stamp;
      case (op)
         OP_FIXED: begin
            fixed_stamp = fixed_stamp + TOTAL_W'(fixed_interval_us);
            stamp = fixed_stamp;
         end
         OP_RESET: begin
            micro_total  = '0;
            carry_cycles = '0;
            fixed_stamp  = '0;
            last_count   = count;
            stamp = '0;
         end
         default: begin
            // The spare op code behaves as a sample request.
            delta    = count - last_count;
            dividend = DIVIDEND_W'(delta) + DIVIDEND_W'(carry_cycles);
            divisor  = DIVIDEND_W'(tick_rate);
            last_count   = count;
            carry_cycles = '0;
            if (tick_rate != '0) begin
               quotient     = dividend / divisor;
               micro_total  = micro_total + quotient[TOTAL_W-1:0];
               carry_cycles = CPU_W'(dividend % divisor);
            end
            stamp = micro_total;
         end
      endcase
      expected_stamps.push_back(stamp);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         tick_rate         = CPU_RESET;
         fixed_interval_us = INTERVAL_RESET;
         last_count        = '0;
         micro_total       = '0;
         carry_cycles      = '0;
         fixed_stamp       = '0;
         mismatches        = 0;
         checked           = 0;
         expected_stamps.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_TICK_RATE:         tick_rate = csr_wdata[CPU_W-1:0];
               CSR_FIXED_INTERVAL_US: fixed_interval_us = csr_wdata;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            predict_timestamp(req_tuser, req_tdata);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_stamps.size() == 0) begin
               if (mismatches < 10) begin
                  $display("Unexpected response transfer: timestamp_us %0d", rsp_tdata);
               end
               mismatches++;
            end else begin
               checked++;
               if (rsp_tdata !== expected_stamps[0]) begin
                  if (mismatches < 10) begin
                     $display("Mismatch on timestamp_us: expected %0d, got %0d",
                              expected_stamps[0], rsp_tdata);
                  end
                  mismatches++;
               end
               void'(expected_stamps.pop_front());
            end
         end
      end
      pending = expected_stamps.size();
   end

endmodule

/* tb/tb_cycles_to_microsecond_timestamp.sv */
`timescale 1ns / 1ps

module tb_cycles_to_microsecond_timestamp;
   import ctmt_pkg::*;

   localparam logic [OP_W-1:0] OP_SPARE = 2'd3;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PHASE_COUNT = 10;
   localparam int PHASE_ITEMS = 65;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [COUNT_W-1:0]     req_tdata = '0;
   logic [OP_W-1:0]        req_tuser = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [TOTAL_W-1:0]     rsp_tdata;
   logic                   csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   int mismatches;
   int pending;
   int checked;
   int requests_sent = 0;
   int register_writes = 0;
   int quiet_cycles = 0;
   int rsp_stall_left = 0;
   bit idling = 1'b1;
   logic [COUNT_W-1:0] cycle_now = '0;

   cycles_to_microsecond_timestamp dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   ctmt_timestamp_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .mismatches (mismatches),
      .pending    (pending),
      .checked    (checked)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("tb: failure");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   always @(negedge clock) begin
      if (idling && rsp_stall_left > 0) begin
         rsp_tready = 1'b0;
         rsp_stall_left--;
      end else if (idling && $urandom_range(0, 5) == 0) begin
         rsp_tready = 1'b0;
         rsp_stall_left = $urandom_range(0, 13);
      end else begin
         rsp_tready = 1'b1;
      end
   end

   // Called at a falling edge; returns at the falling edge after the transfer
   // with tvalid still high, so back-to-back requests are possible.
   task automatic send_request(input logic [OP_W-1:0] op, input logic [COUNT_W-1:0] count);
      if (idling && $urandom_range(0, 4) == 0) begin
         req_tvalid = 1'b0;
         repeat ($urandom_range(1, 14)) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser  = op;
      req_tdata  = count;
      if (op != OP_FIXED) begin
         cycle_now = count;
      end
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
      requests_sent++;
   endtask

   task automatic drain;
      req_tvalid = 1'b0;
      while (pending != 0) @(negedge clock);
   endtask

   task automatic write_register(input csr_index_type index,
                                 input logic [CSR_DATA_W-1:0] value);
      csr_we    = 1'b1;
      csr_index = index;
      csr_wdata = value;
      @(negedge clock);
      csr_we = 1'b0;
      register_writes++;
   endtask

   function automatic logic [OP_W-1:0] pick_op();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return OP_SAMPLE;
      if (roll < 67) return OP_SPARE;
      if (roll < 92) return OP_FIXED;
      return OP_RESET;
   endfunction

   initial begin
      logic [CPU_W-1:0]      cpu_setting;
      logic [INTERVAL_W-1:0] interval_setting;
      logic [COUNT_W-1:0]    count;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part with the reset register values.
      send_request(OP_SAMPLE, 32'd0);
      send_request(OP_SAMPLE, 32'd167);
      send_request(OP_SAMPLE, 32'd336);
      send_request(OP_SPARE, 32'd1000);
      send_request(OP_FIXED, $urandom);
      send_request(OP_FIXED, $urandom);
      send_request(OP_RESET, 32'hFFFF_FF00);
      send_request(OP_SAMPLE, 32'h0000_0100);
      send_request(OP_SAMPLE, 32'hFFFF_FFFF);
      send_request(OP_RESET, 32'hFFFF_FFFF);
      send_request(OP_SAMPLE, 32'hFFFF_FFFE);
      send_request(OP_FIXED, 32'hFFFF_FFFF);

      // A zero divisor freezes the total; the upper write bits are ignored.
      drain();
      write_register(CSR_TICK_RATE, 16'hFC00);
      write_register(CSR_FIXED_INTERVAL_US, 16'hFFFF);
      send_request(OP_SAMPLE, 32'd5000);
      send_request(OP_SPARE, 32'd9000);
      send_request(OP_FIXED, $urandom);
      send_request(OP_FIXED, $urandom);

      // One cycle per microsecond with huge differences wraps the total.
      drain();
      write_register(CSR_TICK_RATE, 16'd1);
      write_register(CSR_FIXED_INTERVAL_US, 16'd0);
      send_request(OP_SAMPLE, cycle_now + 32'hFFFF_FFFF);
      send_request(OP_SAMPLE, cycle_now + 32'hFFFF_FFFF);
      send_request(OP_SAMPLE, cycle_now + 32'hFFFF_FFF0);
      send_request(OP_FIXED, $urandom);

      // Leave a large remainder, then lower the divisor before it is used.
      drain();
      write_register(CSR_TICK_RATE, 16'd1023);
      send_request(OP_SAMPLE, cycle_now + 32'd1022);
      drain();
      write_register(CSR_TICK_RATE, 16'd3);
      send_request(OP_SAMPLE, cycle_now);
      send_request(OP_RESET, 32'd0);
      send_request(OP_SAMPLE, 32'd0);

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         drain();
         case ($urandom_range(0, 9))
            0: cpu_setting = '0;
            1: cpu_setting = 10'd1;
            2: cpu_setting = 10'd1023;
            3: cpu_setting = CPU_RESET;
            4: cpu_setting = 10'd2;
            default: cpu_setting = 10'($urandom_range(1, 1023));
         endcase
         case ($urandom_range(0, 5))
            0: interval_setting = '0;
            1: interval_setting = 16'hFFFF;
            default: interval_setting = 16'($urandom_range(0, 65535));
         endcase
         write_register(CSR_TICK_RATE, {6'($urandom_range(0, 63)), cpu_setting});
         write_register(CSR_FIXED_INTERVAL_US, interval_setting);
         idling = (phase < PHASE_COUNT - 2) && ($urandom_range(0, 3) != 0);
         for (int item = 0; item < PHASE_ITEMS; item++) begin
            case ($urandom_range(0, 19))
               0: count = $urandom;
               1: count = cycle_now + (32'hFFFF_FFFF - 32'($urandom_range(0, 2000)));
               2: count = cycle_now;
               default: count = cycle_now + 32'($urandom_range(0, 5000));
            endcase
            send_request(pick_op(), count);
         end
      end

      drain();
      repeat (60) @(negedge clock);
      $display("Sent %0d requests covering all four op codes over %0d register writes.",
               requests_sent, register_writes);
      $display("Compared %0d response transfers, %0d mismatches.", checked, mismatches);
      if (mismatches == 0 && pending == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

/* files.f */
src/ctmt_pkg.sv
src/ctmt_div.sv
src/cycles_to_microsecond_timestamp.sv
src/ctmt_checker.sv
tb/ctmt_timestamp_checker.sv
tb/tb_cycles_to_microsecond_timestamp.sv
